// ----- sv/vca_pkg.sv -----
package vca_pkg;

  localparam int unsigned MaxChannelsDef = 32;
  localparam int unsigned MaxGroupDef    = 8;

  localparam int unsigned OpW   = 2;
  localparam int unsigned StW   = 2;
  localparam int unsigned ChW   = 5;
  localparam int unsigned TagW  = 31;
  localparam int unsigned OwnW  = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned AgeW  = 8;
  localparam int unsigned CntW  = 6;
  localparam int unsigned NeedW = 4;
  localparam int unsigned MaskW = 32;
  localparam int unsigned IdW   = TagW - ChW;
  localparam int unsigned InW   = 120;
  localparam int unsigned OutW  = 72;

  localparam logic [AgeW-1:0] AgeLimit   = 8'h65;
  localparam logic [CntW-1:0] CountReset = 6'd24;

  typedef enum logic [OpW-1:0] {
    OpAlloc  = 2'd0,
    OpFree   = 2'd1,
    OpLookup = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [StW-1:0] {
    StOk    = 2'd0,
    StFail  = 2'd1,
    StRange = 2'd2,
    StStale = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RdScan  = 2'd0,
    RdSlot  = 2'd1,
    RdLink  = 2'd2,
    RdQuery = 2'd3
  } rd_sel_e;

  typedef struct packed {
    logic    load_in;
    logic    scan_clr;
    logic    scan_step;
    logic    pick;
    logic    set_steal;
    logic    slot_clr;
    logic    slot_inc;
    logic    latch_ent;
    logic    emit_alloc;
    logic    commit;
    logic    emit_fail;
    logic    emit_free;
    logic    emit_lookup;
    rd_sel_e rd_sel;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic need_bad;
    logic scan_last;
    logic found;
    logic steal;
    logic group_full;
    logic slot_last;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/vca_ctrl.sv -----
module vca_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  vca_pkg::sts_t sts_i,
  output logic          ready_o,
  output vca_pkg::cmd_t cmd_o
);
  import vca_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SDisp   = 4'd1;
  localparam logic [3:0] SScan   = 4'd2;
  localparam logic [3:0] SPick   = 4'd3;
  localparam logic [3:0] SEmitA  = 4'd4;
  localparam logic [3:0] SEmitB  = 4'd5;
  localparam logic [3:0] SCommit = 4'd6;
  localparam logic [3:0] SFail   = 4'd7;
  localparam logic [3:0] SFree   = 4'd8;
  localparam logic [3:0] SLook   = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign ready_o = (state_q == SIdle);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.rd_sel = RdScan;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_o.load_in = 1'b1;
          state_d = SDisp;
        end
      end
      SDisp: begin
        unique case (sts_i.op)
          OpAlloc: begin
            if (sts_i.need_bad) begin
              state_d = SFail;
            end else begin
              cmd_o.scan_clr = 1'b1;
              state_d = SScan;
            end
          end
          OpFree:   state_d = SFree;
          OpLookup: state_d = SLook;
          default:  state_d = SIdle;
        endcase
      end
      SScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = SPick;
        end
      end
      SPick: begin
        if (sts_i.found) begin
          cmd_o.pick = 1'b1;
          if (sts_i.group_full) begin
            cmd_o.slot_clr = 1'b1;
            state_d = SEmitA;
          end else begin
            cmd_o.scan_clr = 1'b1;
            state_d = SScan;
          end
        end else if (!sts_i.steal) begin
          cmd_o.set_steal = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d = SScan;
        end else begin
          state_d = SFail;
        end
      end
      SEmitA: begin
        cmd_o.rd_sel = RdSlot;
        cmd_o.latch_ent = 1'b1;
        state_d = SEmitB;
      end
      SEmitB: begin
        cmd_o.rd_sel = RdLink;
        if (sts_i.out_free) begin
          cmd_o.emit_alloc = 1'b1;
          if (sts_i.slot_last) begin
            cmd_o.slot_clr = 1'b1;
            state_d = SCommit;
          end else begin
            cmd_o.slot_inc = 1'b1;
            state_d = SEmitA;
          end
        end
      end
      SCommit: begin
        cmd_o.commit = 1'b1;
        if (sts_i.slot_last) begin
          state_d = SIdle;
        end else begin
          cmd_o.slot_inc = 1'b1;
        end
      end
      SFail: begin
        if (sts_i.out_free) begin
          cmd_o.emit_fail = 1'b1;
          state_d = SIdle;
        end
      end
      SFree: begin
        if (sts_i.out_free) begin
          cmd_o.emit_free = 1'b1;
          state_d = SIdle;
        end
      end
      SLook: begin
        cmd_o.rd_sel = RdQuery;
        if (sts_i.out_free) begin
          cmd_o.emit_lookup = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

endmodule

// ----- sv/vca_dp.sv -----
module vca_dp #(
  parameter int unsigned MAX_CHANNELS = vca_pkg::MaxChannelsDef,
  parameter int unsigned MAX_GROUP    = vca_pkg::MaxGroupDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vca_pkg::cmd_t               cmd_i,
  output vca_pkg::sts_t               sts_o,
  input  logic [vca_pkg::CntW-1:0]    cfg_count_i,
  input  logic [vca_pkg::OpW-1:0]     in_op_i,
  input  logic [vca_pkg::MaskW-1:0]   in_mask_i,
  input  logic [vca_pkg::NeedW-1:0]   in_need_i,
  input  logic [vca_pkg::AgeW-1:0]    in_age_i,
  input  logic [vca_pkg::ChW-1:0]     in_free_i,
  input  logic [vca_pkg::OwnW-1:0]    in_query_i,
  input  logic [vca_pkg::TimeW-1:0]   in_now_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [vca_pkg::StW-1:0]     out_status_o,
  output logic [vca_pkg::ChW-1:0]     out_channel_o,
  output logic [vca_pkg::TagW-1:0]    out_tag_o,
  output logic                        out_stolen_o,
  output logic [vca_pkg::OwnW-1:0]    out_owner_o,
  output logic                        out_last_o
);
  import vca_pkg::*;

  localparam int unsigned IdxW  = $clog2(MAX_CHANNELS);
  localparam int unsigned SlotW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned GotW  = $clog2(MAX_GROUP + 1);

  logic             use_q  [MAX_CHANNELS];
  logic [AgeW-1:0]  age_q  [MAX_CHANNELS];
  logic [TimeW-1:0] time_q [MAX_CHANNELS];
  logic [OwnW-1:0]  own_q  [MAX_CHANNELS];
  logic [IdxW-1:0]  link_q [MAX_CHANNELS];

  op_e              op_q;
  logic [MaskW-1:0] mask_q;
  logic [NeedW-1:0] need_q;
  logic [AgeW-1:0]  vage_q;
  logic [ChW-1:0]   free_q;
  logic [OwnW-1:0]  query_q;
  logic [TimeW-1:0] now_q;
  logic [IdW-1:0]   id_q;

  logic [IdxW-1:0]         c_q, best_q;
  logic                    found_q, steal_q;
  logic [AgeW-1:0]         bage_q;
  logic [TimeW-1:0]        btime_q;
  logic [MAX_CHANNELS-1:0] taken_q;
  logic [GotW-1:0]         got_q;
  logic [SlotW-1:0]        slot_q;
  logic [IdxW-1:0]         chosen_q [MAX_GROUP];
  logic                    ent_use_q;
  logic [OwnW-1:0]         ent_own_q;

  logic             out_valid_q;
  logic [StW-1:0]   out_status_q;
  logic [ChW-1:0]   out_channel_q;
  logic [TagW-1:0]  out_tag_q;
  logic             out_stolen_q;
  logic [OwnW-1:0]  out_owner_q;
  logic             out_last_q;

  logic [CntW-1:0]  n_cnt;
  logic [IdxW-1:0]  rd_idx, slot_ch, prim, query_idx, free_idx;
  logic             rd_use;
  logic [AgeW-1:0]  rd_age;
  logic [TimeW-1:0] rd_time;
  logic [OwnW-1:0]  rd_own;
  logic             cand, better, out_free, query_bad, query_stale, free_ok;
  logic [TagW-1:0]  tag;
  logic [OwnW-1:0]  stolen_owner;

  assign n_cnt = (cfg_count_i > CntW'(MAX_CHANNELS)) ? CntW'(MAX_CHANNELS) : cfg_count_i;
  assign slot_ch   = chosen_q[slot_q];
  assign prim      = chosen_q[0];
  assign query_idx = query_q[IdxW-1:0];
  assign free_idx  = free_q[IdxW-1:0];
  assign tag       = {id_q, ChW'(prim)};
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RdScan:  rd_idx = c_q;
      RdSlot:  rd_idx = slot_ch;
      RdLink:  rd_idx = link_q[slot_ch];
      RdQuery: rd_idx = query_idx;
      default: rd_idx = c_q;
    endcase
  end

  assign rd_use  = use_q[rd_idx];
  assign rd_age  = age_q[rd_idx];
  assign rd_time = time_q[rd_idx];
  assign rd_own  = own_q[rd_idx];

  assign cand = mask_q[c_q] && !taken_q[c_q] && (CntW'(c_q) < n_cnt) &&
                (steal_q ? (rd_age < AgeLimit) : !rd_use);
  assign better = !found_q ||
                  (steal_q ? ((rd_age < bage_q) || ((rd_age == bage_q) && (rd_time < btime_q)))
                           : (rd_time < btime_q));

  assign stolen_owner = !ent_use_q ? '0 : (ent_own_q[OwnW-1] ? rd_own : ent_own_q);
  assign query_bad    = query_q[OwnW-1] || (CntW'(query_q[ChW-1:0]) >= n_cnt);
  assign query_stale  = !rd_use || (rd_own != query_q);
  assign free_ok      = (CntW'(free_q) < CntW'(MAX_CHANNELS));

  assign sts_o.op         = op_q;
  assign sts_o.need_bad   = (need_q == '0) || (int'(need_q) > int'(MAX_GROUP));
  assign sts_o.scan_last  = (int'(c_q) == int'(MAX_CHANNELS) - 1);
  assign sts_o.found      = found_q;
  assign sts_o.steal      = steal_q;
  assign sts_o.group_full = (int'(got_q) + 1 == int'(need_q));
  assign sts_o.slot_last  = (int'(slot_q) + 1 == int'(got_q));
  assign sts_o.out_free   = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q    <= op_e'(in_op_i);
      mask_q  <= in_mask_i;
      need_q  <= in_need_i;
      vage_q  <= in_age_i;
      free_q  <= in_free_i;
      query_q <= in_query_i;
      now_q   <= in_now_i;
    end
    if (cmd_i.scan_step && cand && better) begin
      best_q  <= c_q;
      bage_q  <= rd_age;
      btime_q <= rd_time;
    end
    if (cmd_i.pick) begin
      chosen_q[got_q[SlotW-1:0]] <= best_q;
    end
    if (cmd_i.latch_ent) begin
      ent_use_q <= rd_use;
      ent_own_q <= rd_own;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q    <= '0;
      c_q     <= '0;
      found_q <= 1'b0;
      steal_q <= 1'b0;
      taken_q <= '0;
      got_q   <= '0;
      slot_q  <= '0;
    end else begin
      if (cmd_i.load_in) begin
        steal_q <= 1'b0;
        taken_q <= '0;
        got_q   <= '0;
        if (op_e'(in_op_i) == OpAlloc) begin
          id_q <= id_q + 1'b1;
        end
      end
      if (cmd_i.scan_clr) begin
        c_q     <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        c_q <= c_q + 1'b1;
        if (cand) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.set_steal) begin
        steal_q <= 1'b1;
      end
      if (cmd_i.pick) begin
        taken_q[best_q] <= 1'b1;
        got_q <= got_q + 1'b1;
      end
      if (cmd_i.slot_clr) begin
        slot_q <= '0;
      end else if (cmd_i.slot_inc) begin
        slot_q <= slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_CHANNELS); i++) begin
        use_q[i]  <= 1'b0;
        age_q[i]  <= '0;
        time_q[i] <= '0;
        own_q[i]  <= '0;
        link_q[i] <= '0;
      end
    end else begin
      if (cmd_i.emit_alloc) begin
        use_q[slot_ch]  <= 1'b1;
        time_q[slot_ch] <= now_q;
        age_q[slot_ch]  <= vage_q;
      end
      if (cmd_i.commit) begin
        if (slot_q == '0) begin
          own_q[slot_ch] <= {1'b0, tag};
        end else begin
          own_q[slot_ch]  <= '1;
          link_q[slot_ch] <= prim;
        end
      end
      if (cmd_i.emit_free && free_ok) begin
        use_q[free_idx]  <= 1'b0;
        time_q[free_idx] <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_alloc || cmd_i.emit_fail || cmd_i.emit_free ||
                 cmd_i.emit_lookup) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_alloc) begin
      out_status_q  <= StOk;
      out_channel_q <= ChW'(slot_ch);
      out_tag_q     <= tag;
      out_stolen_q  <= ent_use_q;
      out_owner_q   <= stolen_owner;
      out_last_q    <= sts_o.slot_last;
    end else if (cmd_i.emit_fail) begin
      out_status_q  <= StFail;
      out_channel_q <= '0;
      out_tag_q     <= '0;
      out_stolen_q  <= 1'b0;
      out_owner_q   <= '0;
      out_last_q    <= 1'b1;
    end else if (cmd_i.emit_free) begin
      out_status_q  <= StOk;
      out_channel_q <= free_q;
      out_tag_q     <= '0;
      out_stolen_q  <= 1'b0;
      out_owner_q   <= '0;
      out_last_q    <= 1'b1;
    end else if (cmd_i.emit_lookup) begin
      out_status_q  <= query_bad ? StRange : (query_stale ? StStale : StOk);
      out_channel_q <= query_bad ? '0 : query_q[ChW-1:0];
      out_tag_q     <= '0;
      out_stolen_q  <= 1'b0;
      out_owner_q   <= '0;
      out_last_q    <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_channel_o = out_channel_q;
  assign out_tag_o     = out_tag_q;
  assign out_stolen_o  = out_stolen_q;
  assign out_owner_o   = out_owner_q;
  assign out_last_o    = out_last_q;

endmodule

// ----- sv/voice_channel_allocator_core.sv -----
// Free and lookup pass through a dispatch state and then register their output word; the
// next input word is accepted once the controller is back in idle.
// Allocation makes one scan pass over all MAX_CHANNELS channels per chosen voice, plus one
// more pass when the idle search runs dry, then emits each output word through a slot-read
// and a link-read state and commits each voice before ready is raised again.
// One input word is in flight at a time. Reset clears all channel state, the id
// counter and sets channel_count to 24.
module voice_channel_allocator_core #(
  parameter int unsigned MAX_CHANNELS = vca_pkg::MaxChannelsDef,
  parameter int unsigned MAX_GROUP    = vca_pkg::MaxGroupDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [vca_pkg::CntW-1:0]  cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // eligible_mask, voices_needed, voice_age, free_channel, query_tag, now_time
  input  logic [vca_pkg::InW-1:0]   s_axis_tdata,
  // operation
  input  logic [vca_pkg::OpW-1:0]   s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // channel, alloc_tag, was_stolen, stolen_owner
  output logic [vca_pkg::OutW-1:0]  m_axis_tdata,
  // status
  output logic [vca_pkg::StW-1:0]   m_axis_tuser,
  output logic                      m_axis_tlast
);
  import vca_pkg::*;

  logic [CntW-1:0] count_q;
  cmd_t            cmd;
  sts_t            sts;
  logic            ready;
  logic [ChW-1:0]  out_channel;
  logic [TagW-1:0] out_tag;
  logic            out_stolen;
  logic [OwnW-1:0] out_owner;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = ready;

  vca_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_axis_tvalid),
    .sts_i   (sts),
    .ready_o (ready),
    .cmd_o   (cmd)
  );

  vca_dp #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_GROUP    (MAX_GROUP)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_count_i   (count_q),
    .in_op_i       (s_axis_tuser),
    .in_mask_i     (s_axis_tdata[31:0]),
    .in_need_i     (s_axis_tdata[35:32]),
    .in_age_i      (s_axis_tdata[43:36]),
    .in_free_i     (s_axis_tdata[48:44]),
    .in_query_i    (s_axis_tdata[80:49]),
    .in_now_i      (s_axis_tdata[112:81]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_status_o  (m_axis_tuser),
    .out_channel_o (out_channel),
    .out_tag_o     (out_tag),
    .out_stolen_o  (out_stolen),
    .out_owner_o   (out_owner),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_owner, out_stolen, out_tag, out_channel};

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a word while busy");

  a_multi_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == StOk)
    else $error("non-final word without ok status");

  a_stolen_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_stolen |-> m_axis_tuser == StOk)
    else $error("stolen flag on a failed result");

endmodule
